FILE: hw/rtl/gfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_pkg
// Shared types and constants for the gyro frame parser.
// ----------------------------------------------------------------------------
package gfp_pkg;

    localparam logic [7:0]  HDR_BYTE = 8'hFF;
    localparam logic [15:0] CK_BIAS  = 16'hFFFF;

    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_CK_ERR = 1'b1;

    typedef struct packed {
        logic signed [15:0] rate_hundredths;
        logic signed [15:0] angle_hundredths;
        logic               frame_status;
    } gfp_result_t;

endpackage

FILE: hw/rtl/gfp_framer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_framer
// Header hunt, payload capture and checksum check, one byte per beat.
// ----------------------------------------------------------------------------
module gfp_framer
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_accept,
    input  logic [7:0]           rx_byte,
    output logic                 res_valid,
    output gfp_pkg::gfp_result_t res_data
);
    import gfp_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT0 = 3'd0,
        PH_HUNT1 = 3'd1,
        PH_D0    = 3'd2,
        PH_D1    = 3'd3,
        PH_D2    = 3'd4,
        PH_D3    = 3'd5,
        PH_D4    = 3'd6,
        PH_D5    = 3'd7
    } phase_t;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [7:0]  payload_reg [5];
    logic [15:0] rate_w;
    logic [15:0] angle_w;
    logic [15:0] sum_w;
    logic [15:0] got_w;

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HUNT0: phase_next = (rx_byte == HDR_BYTE) ? PH_HUNT1 : PH_HUNT0;
            PH_HUNT1: phase_next = (rx_byte == HDR_BYTE) ? PH_D0 : PH_HUNT0;
            PH_D0:    phase_next = PH_D1;
            PH_D1:    phase_next = PH_D2;
            PH_D2:    phase_next = PH_D3;
            PH_D3:    phase_next = PH_D4;
            PH_D4:    phase_next = PH_D5;
            PH_D5:    phase_next = PH_HUNT0;
            default:  phase_next = PH_HUNT0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT0;
        end
        else if (byte_accept)
        begin
            phase_reg <= phase_next;
        end
    end

    // capture payload bytes 0..4
    always_ff @(posedge clk)
    begin
        if (byte_accept)
        begin
            case (phase_reg)
                PH_D0:   payload_reg[0] <= rx_byte;
                PH_D1:   payload_reg[1] <= rx_byte;
                PH_D2:   payload_reg[2] <= rx_byte;
                PH_D3:   payload_reg[3] <= rx_byte;
                PH_D4:   payload_reg[4] <= rx_byte;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        rate_w  = {payload_reg[1], payload_reg[0]};
        angle_w = {payload_reg[3], payload_reg[2]};
        sum_w   = CK_BIAS + rate_w + angle_w;
        got_w   = {rx_byte, payload_reg[4]};

        res_valid                 = byte_accept && (phase_reg == PH_D5);
        res_data.rate_hundredths  = signed'(rate_w);
        res_data.angle_hundredths = signed'(angle_w);
        res_data.frame_status     = (sum_w == got_w) ? STATUS_OK : STATUS_CK_ERR;
    end

endmodule

FILE: hw/rtl/gfp_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfp_out_stage
// Result register with a one-entry skid buffer toward the output channel.
// ----------------------------------------------------------------------------
module gfp_out_stage
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 res_valid,
    input  gfp_pkg::gfp_result_t res_data,
    output logic                 skid_full,
    output logic                 out_valid,
    input  logic                 out_stall,
    output gfp_pkg::gfp_result_t out_data
);
    import gfp_pkg::*;

    logic        main_valid_reg;
    logic        skid_valid_reg;
    gfp_result_t main_reg;
    gfp_result_t skid_reg;
    logic        main_free;

    assign main_free = !main_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (main_free)
        begin
            main_valid_reg <= skid_valid_reg || res_valid;
            skid_valid_reg <= 1'b0;
        end
        else if (res_valid)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (main_free)
        begin
            main_reg <= skid_valid_reg ? skid_reg : res_data;
        end
        else if (res_valid)
        begin
            skid_reg <= res_data;
        end
    end

    assign skid_full = skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

endmodule

FILE: hw/rtl/gyro_frame_parser_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gyro_frame_parser_top
// Gyro serial frame parser: hunts 0xFF 0xFF, collects six payload bytes,
// reports rate, angle and checksum status for every frame.
// ----------------------------------------------------------------------------
//  channel | handshake                     | payload
//  --------+-------------------------------+-------------------------------------
//  input   | in_valid / in_stall (driven)  | rx_byte[7:0]
//  output  | out_valid / out_stall (taken) | rate_hundredths, angle_hundredths,
//          |                               | frame_status
//
//  One byte is taken every cycle while in_stall is low; a frame's result is
//  registered with its eighth byte, or held in the skid entry if output stalls.
//  Reset returns the parser to the header hunt and empties the output stage.
//  in_stall rises only while the skid entry holds a result behind a stalled
//  output register.
// ----------------------------------------------------------------------------
module gyro_frame_parser_top
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         rx_byte,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [15:0] rate_hundredths,
    output logic signed [15:0] angle_hundredths,
    output logic               frame_status
);
    import gfp_pkg::*;

    logic        byte_accept;
    logic        res_valid;
    logic        skid_full;
    gfp_result_t res_data;
    gfp_result_t out_data;

    assign in_stall    = skid_full;
    assign byte_accept = in_valid && !skid_full;

    gfp_framer u_framer
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .rx_byte     (rx_byte),
        .res_valid   (res_valid),
        .res_data    (res_data)
    );

    gfp_out_stage u_out_stage
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res_data  (res_data),
        .skid_full (skid_full),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    assign rate_hundredths  = out_data.rate_hundredths;
    assign angle_hundredths = out_data.angle_hundredths;
    assign frame_status     = out_data.frame_status;

endmodule
